// ===== sv/ipv6_neighbour_cache_macros.svh =====
// assertion helpers for the neighbour cache
`ifndef IPV6_NEIGHBOUR_CACHE_MACROS_SVH
`define IPV6_NEIGHBOUR_CACHE_MACROS_SVH
// implication checked on every clock edge outside reset
`define NC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the next cycle after the antecedent
`define NC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/nc_pkg.sv =====
// ----------------------------------------------------------------------------
// nc_pkg
// types and constants shared by the neighbour cache
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nc_pkg;
  localparam logic [2:0] StNone       = 3'd0;
  localparam logic [2:0] StIncomplete = 3'd1;
  localparam logic [2:0] StReachable  = 3'd2;
  localparam logic [2:0] StStale      = 3'd3;
  localparam logic [2:0] StDelay      = 3'd4;
  localparam logic [2:0] StProbe      = 3'd5;

  localparam logic [1:0] OpResolve = 2'd0;
  localparam logic [1:0] OpLearn   = 2'd1;
  localparam logic [1:0] OpTick    = 2'd2;
  localparam logic [1:0] OpQuery   = 2'd3;

  localparam logic [1:0] KindAnswer  = 2'd0;
  localparam logic [1:0] KindSolicit = 2'd1;
  localparam logic [1:0] KindDone    = 2'd2;

  localparam logic [1:0] RegReachable  = 2'd0;
  localparam logic [1:0] RegRetransmit = 2'd1;
  localparam logic [1:0] RegProbeDelay = 2'd2;

  localparam logic [18:0] ReachableReset  = 19'd3000;
  localparam logic [18:0] RetransmitReset = 19'd100;
  localparam logic [18:0] ProbeDelayReset = 19'd500;
  localparam logic [1:0]  MaxSolicits     = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [47:0] learned_mac;
    logic        has_mac;
    logic        solicited_flag;
    logic        override_flag;
    logic        router_flag;
    logic [63:0] now_ticks;
  } nc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [47:0] mac_out;
    logic [63:0] target_high;
    logic [63:0] target_low;
    logic        unicast;
    logic [2:0]  state_out;
    logic        last;
  } nc_out_t;

  function automatic logic [1:0] evict_rank(input logic [2:0] st);
    logic [1:0] r;
    case (st)
      StReachable:       r = 2'd3;
      StStale:           r = 2'd1;
      StDelay, StProbe:  r = 2'd2;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== sv/ipv6_neighbour_cache.sv =====
// ----------------------------------------------------------------------------
// ipv6_neighbour_cache
// neighbour cache with reachability tracking, one shared compare unit
// ----------------------------------------------------------------------------
// Each transaction walks the entries one per cycle through a single address
// compare. Resolve, learn and query then update the chosen entry where needed
// and report; a resolve miss sends a solicitation before its answer. A tick
// then revisits every entry through a single deadline compare, in the read,
// tick and emit states in turn. A result that waits on the output stalls the
// transaction. Entry storage needs no clearing pass.
`timescale 1ns / 1ps
`include "ipv6_neighbour_cache_macros.svh"
module ipv6_neighbour_cache
  import nc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nc_in_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output nc_out_t     out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [18:0] cfg_data_i
);
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IW:0] LastIdx = (IW+1)'(CACHE_ENTRIES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_TICK  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  nc_in_t      req_q;
  logic [18:0] reach_q, retx_q, pdly_q;

  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [2:0]  est_q [CACHE_ENTRIES];
  logic [1:0]  prb_q [CACHE_ENTRIES];
  logic        rtr_q [CACHE_ENTRIES];
  logic [63:0] ahi_m [CACHE_ENTRIES];
  logic [63:0] alo_m [CACHE_ENTRIES];
  logic [47:0] mac_m [CACHE_ENTRIES];
  logic [63:0] dl_m  [CACHE_ENTRIES];

  logic [IW-1:0] idx_q;
  logic          found_q, free_q;
  logic [IW-1:0] fidx_q, freeidx_q, vidx_q;
  logic [1:0]    vrank_q;
  logic          vany_q;
  logic [63:0]   rd_ahi_q, rd_alo_q, rd_mac_q, rd_dl_q;
  logic [63:0]   sum_q;
  logic          pend_q;   // pending result: answer after solicitation, or done after a tick
  nc_out_t       pend_d_q;
  nc_out_t       out_q;
  logic          ovalid_q;

  logic [IW-1:0] rd_idx;
  logic          match;
  logic [IW-1:0] tgt;
  assign tgt    = found_q ? fidx_q : (free_q ? freeidx_q : vidx_q);
  assign rd_idx = (st_q == S_SCAN) ? idx_q : ((req_q.opcode == OpTick) ? idx_q : tgt);
  assign match  = valid_q[idx_q] && (ahi_m[idx_q] == req_q.addr_high)
                  && (alo_m[idx_q] == req_q.addr_low);

  // registered memory reads
  always_ff @(posedge clk_i) begin
    rd_ahi_q <= ahi_m[rd_idx];
    rd_alo_q <= alo_m[rd_idx];
    rd_mac_q <= {16'd0, mac_m[rd_idx]};
    rd_dl_q  <= dl_m[rd_idx];
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          wr_addr, wr_mac, wr_dl;
  logic [47:0]   wr_mac_v;
  logic [63:0]   wr_dl_v;
  logic [2:0]    cur_st;
  logic          tick_last;
  logic [63:0]   now;

  assign now       = req_q.now_ticks;
  assign cur_st    = est_q[tgt];
  assign tick_last = ({1'b0, idx_q} == LastIdx);

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr) begin
      ahi_m[wr_idx] <= req_q.addr_high;
      alo_m[wr_idx] <= req_q.addr_low;
    end
    if (wr_en && wr_mac) mac_m[wr_idx] <= wr_mac_v;
    if (wr_en && wr_dl)  dl_m[wr_idx]  <= wr_dl_v;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_SCAN;
      S_SCAN: if (tick_last) st_d = S_RD;
      S_RD:   st_d = (req_q.opcode == OpTick) ? S_TICK : S_EXEC;
      S_EXEC: st_d = S_EMIT;
      S_TICK: st_d = S_EMIT;
      S_EMIT: st_d = S_WAIT;
      S_WAIT: st_d = S_WAIT;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      reach_q  <= ReachableReset;
      retx_q   <= RetransmitReset;
      pdly_q   <= ProbeDelayReset;
      valid_q  <= '0;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < CACHE_ENTRIES; i++) est_q[i] <= StNone;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegReachable:  reach_q <= cfg_data_i;
          RegRetransmit: retx_q  <= cfg_data_i;
          RegProbeDelay: pdly_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
            vany_q  <= 1'b0;
            st_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= idx_q;
          end
          if (!valid_q[idx_q] && !free_q) begin
            free_q    <= 1'b1;
            freeidx_q <= idx_q;
          end
          if (!vany_q || evict_rank(est_q[idx_q]) < vrank_q) begin
            vany_q  <= 1'b1;
            vrank_q <= evict_rank(est_q[idx_q]);
            vidx_q  <= idx_q;
          end
          if (tick_last) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
          st_q <= st_d;
        end
        S_RD: begin
          sum_q <= now;
          st_q  <= st_d;
        end
        S_EXEC: begin
          out_q <= '0;
          pend_q <= 1'b0;
          case (req_q.opcode)
            OpResolve: begin
              if (found_q && cur_st >= StReachable && cur_st <= StProbe) begin
                out_q.hit     <= 1'b1;
                out_q.mac_out <= rd_mac_q[47:0];
                out_q.state_out <= (cur_st == StStale) ? StDelay : cur_st;
                out_q.last    <= 1'b1;
                if (cur_st == StStale) begin
                  est_q[tgt] <= StDelay;
                  prb_q[tgt] <= 2'd0;
                end
              end else if (found_q) begin
                out_q.state_out <= cur_st;
                out_q.last      <= 1'b1;
              end else begin
                valid_q[tgt] <= 1'b1;
                est_q[tgt]   <= StIncomplete;
                rtr_q[tgt]   <= 1'b0;
                prb_q[tgt]   <= 2'd1;
                out_q.kind        <= KindSolicit;
                out_q.target_high <= req_q.addr_high;
                out_q.target_low  <= req_q.addr_low;
                out_q.state_out   <= StIncomplete;
                pend_q <= 1'b1;
                pend_d_q <= '{kind: KindAnswer, hit: 1'b0, mac_out: '0,
                              target_high: '0, target_low: '0, unicast: 1'b0,
                              state_out: StIncomplete, last: 1'b1};
              end
            end
            OpLearn: begin
              out_q.kind <= KindDone;
              out_q.last <= 1'b1;
              out_q.state_out <= found_q ? cur_st : StNone;
              if (!found_q || cur_st == StIncomplete) begin
                if (req_q.has_mac) begin
                  valid_q[tgt] <= 1'b1;
                  est_q[tgt] <= req_q.solicited_flag ? StReachable : StStale;
                  rtr_q[tgt] <= req_q.router_flag;
                  if (!found_q) prb_q[tgt] <= 2'd0;
                  out_q.state_out <= req_q.solicited_flag ? StReachable : StStale;
                end
              end else if (req_q.has_mac && rd_mac_q[47:0] != req_q.learned_mac
                           && !req_q.override_flag) begin
                if (cur_st == StReachable) begin
                  est_q[tgt] <= StStale;
                  prb_q[tgt] <= 2'd0;
                  out_q.state_out <= StStale;
                end
              end else begin
                if (req_q.router_flag) rtr_q[tgt] <= 1'b1;
                if (req_q.solicited_flag) begin
                  est_q[tgt] <= StReachable;
                  prb_q[tgt] <= 2'd0;
                  out_q.state_out <= StReachable;
                end else if (req_q.has_mac && rd_mac_q[47:0] != req_q.learned_mac) begin
                  est_q[tgt] <= StStale;
                  prb_q[tgt] <= 2'd0;
                  out_q.state_out <= StStale;
                end
              end
            end
            default: begin
              out_q.state_out <= found_q ? cur_st : StNone;
              out_q.last      <= 1'b1;
            end
          endcase
          ovalid_q <= 1'b1;
          st_q <= S_WAIT;
        end
        S_TICK: begin
          // one entry per visit: rd_* hold entry idx_q
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b0;
            if (valid_q[idx_q] && now >= rd_dl_q) begin
              out_q <= '0;
              out_q.kind        <= KindSolicit;
              out_q.target_high <= rd_ahi_q;
              out_q.target_low  <= rd_alo_q;
              if (est_q[idx_q] == StIncomplete || est_q[idx_q] == StProbe) begin
                if (prb_q[idx_q] >= MaxSolicits) begin
                  valid_q[idx_q] <= 1'b0;
                  est_q[idx_q]   <= StNone;
                end else begin
                  prb_q[idx_q] <= prb_q[idx_q] + 2'd1;
                  out_q.unicast   <= (est_q[idx_q] == StProbe);
                  out_q.state_out <= est_q[idx_q];
                  ovalid_q <= 1'b1;
                end
              end else if (est_q[idx_q] == StReachable) begin
                est_q[idx_q] <= StStale;
                prb_q[idx_q] <= 2'd0;
              end else if (est_q[idx_q] == StDelay) begin
                est_q[idx_q] <= StProbe;
                prb_q[idx_q] <= 2'd1;
                out_q.unicast   <= 1'b1;
                out_q.state_out <= StProbe;
                ovalid_q <= 1'b1;
              end
            end
            st_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // tick: advance to next entry, or finish with done
          if (tick_last) begin
            pend_q <= 1'b1;
            pend_d_q <= '{kind: KindDone, hit: 1'b0, mac_out: '0, target_high: '0,
                          target_low: '0, unicast: 1'b0, state_out: StNone,
                          last: 1'b1};
            st_q <= S_WAIT;
          end else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= S_RD;
          end
        end
        S_WAIT: begin
          if (!ovalid_q || out_ready_i) begin
            if (pend_q) begin
              out_q    <= pend_d_q;
              ovalid_q <= 1'b1;
              pend_q   <= 1'b0;
            end else begin
              st_q <= S_IDLE;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) req_q <= in_data_i;
  end

  // memory write port control
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = tgt;
    wr_addr  = 1'b0;
    wr_mac   = 1'b0;
    wr_dl    = 1'b0;
    wr_mac_v = req_q.learned_mac;
    wr_dl_v  = sum_q;
    if (st_q == S_EXEC) begin
      wr_en = 1'b1;
      case (req_q.opcode)
        OpResolve: begin
          if (found_q && cur_st == StStale) begin
            wr_dl = 1'b1;
            wr_dl_v = now + {45'd0, pdly_q};
          end else if (!found_q) begin
            wr_addr = 1'b1;
            wr_mac  = 1'b1;
            wr_mac_v = '0;
            wr_dl   = 1'b1;
            wr_dl_v = now + {45'd0, retx_q};
          end
        end
        OpLearn: begin
          wr_dl_v = now + {45'd0, reach_q};
          if (!found_q || cur_st == StIncomplete) begin
            if (req_q.has_mac) begin
              wr_addr = !found_q;
              wr_mac  = 1'b1;
              wr_dl   = 1'b1;
            end
          end else if (req_q.has_mac && rd_mac_q[47:0] != req_q.learned_mac
                       && !req_q.override_flag) begin
            wr_en = 1'b0;
          end else begin
            wr_mac = req_q.has_mac && rd_mac_q[47:0] != req_q.learned_mac;
            wr_dl  = req_q.solicited_flag;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end else if (st_q == S_TICK && (!ovalid_q || out_ready_i)) begin
      wr_idx  = idx_q;
      wr_dl_v = now + {45'd0, retx_q};
      if (valid_q[idx_q] && now >= rd_dl_q && (est_q[idx_q] == StDelay
          || ((est_q[idx_q] == StIncomplete || est_q[idx_q] == StProbe)
              && prb_q[idx_q] < MaxSolicits))) begin
        wr_en = 1'b1;
        wr_dl = 1'b1;
      end
    end
  end

  `NC_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, st_q != S_IDLE, !in_ready_o)
  `NC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
  `NC_ASSERT_IMP(a_idle_no_pend, clk_i, rst_ni, st_q == S_IDLE, !pend_q && !out_valid_o)
endmodule

// ===== bench/tb_ipv6_neighbour_cache.sv =====
// ----------------------------------------------------------------------------
// tb_ipv6_neighbour_cache
// self-checking bench for the neighbour cache: directed and random traffic
// ----------------------------------------------------------------------------
// A behavioral copy of the cache predicts every result of each accepted
// transaction; a monitor compares the results field by field in order.
// Timer registers are changed only while the cache is idle.
`timescale 1ns / 1ps
module tb_ipv6_neighbour_cache;
  import nc_pkg::*;

  localparam int Entries = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  nc_in_t      in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  nc_out_t     out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int sent_count = 0;
  int result_count = 0;
  int solicit_count = 0;

  nc_out_t expected_results[$];

  // predicted cache contents
  logic [18:0] reach_ticks, retx_ticks, delay_ticks;
  logic        c_valid[Entries];
  logic [63:0] c_hi[Entries];
  logic [63:0] c_lo[Entries];
  logic [47:0] c_mac[Entries];
  logic [2:0]  c_state[Entries];
  logic        c_router[Entries];
  logic [1:0]  c_probes[Entries];
  logic [63:0] c_deadline[Entries];

  // address pool keeps lookups colliding
  logic [63:0] pool_hi[24];
  logic [63:0] pool_lo[24];
  logic [63:0] clock_now = 64'd0;

  always #10 clk = ~clk;

  ipv6_neighbour_cache dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic logic [1:0] rank_of(logic [2:0] st);
    case (st)
      StReachable: return 2'd3;
      StStale: return 2'd1;
      StDelay, StProbe: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic int lookup_entry(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < Entries; i++)
      if (c_valid[i] && c_hi[i] == hi && c_lo[i] == lo) return i;
    return -1;
  endfunction

  function automatic int claim_entry(logic [63:0] hi, logic [63:0] lo);
    int slot;
    int best;
    slot = -1;
    for (int i = 0; i < Entries; i++)
      if (!c_valid[i] && slot < 0) slot = i;
    if (slot < 0) begin
      best = 9;
      slot = 0;
      for (int i = 0; i < Entries; i++)
        if (rank_of(c_state[i]) < best) begin
          best = rank_of(c_state[i]);
          slot = i;
        end
    end
    c_valid[slot] = 1'b1;
    c_hi[slot] = hi;
    c_lo[slot] = lo;
    c_mac[slot] = '0;
    c_state[slot] = StIncomplete;
    c_router[slot] = 1'b0;
    c_probes[slot] = '0;
    c_deadline[slot] = '0;
    return slot;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic hit, logic [47:0] mac,
                                      logic [63:0] th, logic [63:0] tl, logic uni,
                                      logic [2:0] st);
    nc_out_t r;
    r = '{kind: kind, hit: hit, mac_out: mac, target_high: th, target_low: tl,
          unicast: uni, state_out: st, last: 1'b0};
    expected_results.push_back(r);
  endfunction

  function automatic void apply_learn(nc_in_t t);
    int e;
    logic differs;
    e = lookup_entry(t.addr_high, t.addr_low);
    if (e < 0 || c_state[e] == StIncomplete) begin
      if (!t.has_mac) return;
      if (e < 0) e = claim_entry(t.addr_high, t.addr_low);
      c_mac[e] = t.learned_mac;
      c_state[e] = t.solicited_flag ? StReachable : StStale;
      c_deadline[e] = t.now_ticks + 64'(reach_ticks);
      c_router[e] = t.router_flag;
      return;
    end
    differs = t.has_mac && c_mac[e] != t.learned_mac;
    if (differs && !t.override_flag) begin
      if (c_state[e] == StReachable) begin
        c_state[e] = StStale;
        c_probes[e] = '0;
      end
      return;
    end
    if (differs) c_mac[e] = t.learned_mac;
    if (t.router_flag) c_router[e] = 1'b1;
    if (t.solicited_flag) begin
      c_state[e] = StReachable;
      c_deadline[e] = t.now_ticks + 64'(reach_ticks);
      c_probes[e] = '0;
    end else if (differs) begin
      c_state[e] = StStale;
      c_probes[e] = '0;
    end
  endfunction

  // appends the expected results of one transaction
  function automatic void predict_cache(nc_in_t t);
    int e;
    logic [2:0] st;
    case (t.opcode)
      OpResolve: begin
        e = lookup_entry(t.addr_high, t.addr_low);
        if (e >= 0 && c_state[e] >= StReachable && c_state[e] <= StProbe) begin
          if (c_state[e] == StStale) begin
            c_state[e] = StDelay;
            c_deadline[e] = t.now_ticks + 64'(delay_ticks);
            c_probes[e] = '0;
          end
          push_result(KindAnswer, 1'b1, c_mac[e], '0, '0, 1'b0, c_state[e]);
        end else begin
          if (e < 0) begin
            e = claim_entry(t.addr_high, t.addr_low);
            c_probes[e] = 2'd1;
            c_deadline[e] = t.now_ticks + 64'(retx_ticks);
            push_result(KindSolicit, 1'b0, '0, t.addr_high, t.addr_low, 1'b0, StIncomplete);
          end
          push_result(KindAnswer, 1'b0, '0, '0, '0, 1'b0, c_state[e]);
        end
      end
      OpLearn: begin
        apply_learn(t);
        e = lookup_entry(t.addr_high, t.addr_low);
        push_result(KindDone, 1'b0, '0, '0, '0, 1'b0, e >= 0 ? c_state[e] : StNone);
      end
      OpTick: begin
        for (int i = 0; i < Entries; i++) begin
          if (c_valid[i] && t.now_ticks >= c_deadline[i]) begin
            st = c_state[i];
            if (st == StIncomplete || st == StProbe) begin
              if (c_probes[i] >= MaxSolicits) begin
                c_valid[i] = 1'b0;
                c_state[i] = StNone;
              end else begin
                c_probes[i] = c_probes[i] + 2'd1;
                c_deadline[i] = t.now_ticks + 64'(retx_ticks);
                push_result(KindSolicit, 1'b0, '0, c_hi[i], c_lo[i], st == StProbe, st);
              end
            end else if (st == StReachable) begin
              c_state[i] = StStale;
              c_probes[i] = '0;
            end else if (st == StDelay) begin
              c_state[i] = StProbe;
              c_probes[i] = 2'd1;
              c_deadline[i] = t.now_ticks + 64'(retx_ticks);
              push_result(KindSolicit, 1'b0, '0, c_hi[i], c_lo[i], 1'b1, StProbe);
            end
          end
        end
        push_result(KindDone, 1'b0, '0, '0, '0, 1'b0, StNone);
      end
      default: begin
        e = lookup_entry(t.addr_high, t.addr_low);
        push_result(KindAnswer, 1'b0, '0, '0, '0, 1'b0, e >= 0 ? c_state[e] : StNone);
      end
    endcase
    expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // valid stays high after acceptance until the next transaction or an idle cycle
  task automatic send_request(nc_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cache(t);
    sent_count++;
  endtask

  // monitor
  always @(posedge clk) begin
    nc_out_t e;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d", out_data.kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.kind == KindSolicit) solicit_count++;
        if (out_data.kind != e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
        end
        if (out_data.hit != e.hit) begin
          $error("hit exp %0d got %0d", e.hit, out_data.hit); errors++;
        end
        if (out_data.mac_out != e.mac_out) begin
          $error("mac_out exp %h got %h", e.mac_out, out_data.mac_out); errors++;
        end
        if (out_data.target_high != e.target_high) begin
          $error("target_high exp %h got %h", e.target_high, out_data.target_high); errors++;
        end
        if (out_data.target_low != e.target_low) begin
          $error("target_low exp %h got %h", e.target_low, out_data.target_low); errors++;
        end
        if (out_data.unicast != e.unicast) begin
          $error("unicast exp %0d got %0d", e.unicast, out_data.unicast); errors++;
        end
        if (out_data.state_out != e.state_out) begin
          $error("state_out exp %0d got %0d", e.state_out, out_data.state_out); errors++;
        end
        if (out_data.last != e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_timer(logic [1:0] idx, logic [18:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegReachable) reach_ticks = val;
    else if (idx == RegRetransmit) retx_ticks = val;
    else if (idx == RegProbeDelay) delay_ticks = val;
  endtask

  function automatic nc_in_t make_op(logic [1:0] op, int slot, logic [63:0] now);
    nc_in_t t;
    t = '0;
    t.opcode = op;
    t.addr_high = pool_hi[slot];
    t.addr_low = pool_lo[slot];
    t.learned_mac = {2'($urandom_range(3)), 46'd0} | 48'($urandom_range(3));
    t.has_mac = 1'b1;
    t.now_ticks = now;
    return t;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    nc_in_t t;
    t = make_op(OpQuery, 0, 64'd0); send_request(t);
    t = make_op(OpResolve, 0, 64'd0); send_request(t);
    t = make_op(OpResolve, 0, 64'd1); send_request(t);
    t = make_op(OpLearn, 1, 64'd2); t.has_mac = 1'b0; send_request(t);
    t = make_op(OpLearn, 0, 64'd3); t.has_mac = 1'b0; send_request(t);
    t = make_op(OpLearn, 0, 64'd4); t.solicited_flag = 1'b1; t.router_flag = 1'b1;
    t.learned_mac = '1; send_request(t);
    t = make_op(OpResolve, 0, 64'd5); send_request(t);
    t = make_op(OpLearn, 0, 64'd6); t.learned_mac = '0; send_request(t);
    t = make_op(OpLearn, 0, 64'd7); t.learned_mac = '0; t.override_flag = 1'b1;
    send_request(t);
    t = make_op(OpResolve, 0, 64'd8); send_request(t);
    t = make_op(OpQuery, 0, 64'd9); send_request(t);
    t = make_op(OpLearn, 2, 64'd10); t.solicited_flag = 1'b0; send_request(t);
    t = make_op(OpTick, 0, 64'd50); send_request(t);
    t = make_op(OpTick, 0, 64'd200); send_request(t);
    t = make_op(OpTick, 0, 64'd800); send_request(t);
    t = make_op(OpTick, 0, 64'd1000); send_request(t);
    t = make_op(OpTick, 0, 64'd1200); send_request(t);
    t = make_op(OpTick, 0, 64'd5000); send_request(t);
    t = make_op(OpTick, 0, '1); send_request(t);
    t = '0; t.opcode = OpQuery; t.addr_high = '1; t.addr_low = '1; send_request(t);
  endtask

  // fill the cache past capacity so eviction ranks matter
  task automatic test_eviction();
    nc_in_t t;
    for (int i = 0; i < 20; i++) begin
      t = make_op(i % 3 == 0 ? OpLearn : OpResolve, i, 64'd100 + i);
      t.solicited_flag = i[1];
      send_request(t);
    end
    t = make_op(OpTick, 0, 64'hFFFF_FFFF_FFFF_FFF0); send_request(t);
  endtask

  task automatic test_random(int count);
    nc_in_t t;
    for (int i = 0; i < count; i++) begin
      clock_now += 64'($urandom_range(40));
      if ($urandom_range(9) == 0) begin
        t = '0;
        t.opcode = 2'($urandom_range(3));
        t.addr_high = rand64();
        t.addr_low = rand64();
        t.learned_mac = {$urandom(), 16'($urandom())};
        t.now_ticks = ($urandom_range(3) == 0) ? rand64() : clock_now;
      end else begin
        t = make_op(2'($urandom_range(3)), $urandom_range(23), clock_now);
        if ($urandom_range(3) == 0) t.learned_mac = {$urandom(), 16'($urandom())};
      end
      t.has_mac = $urandom_range(4) != 0;
      t.solicited_flag = 1'($urandom_range(1));
      t.override_flag = 1'($urandom_range(1));
      t.router_flag = 1'($urandom_range(1));
      send_request(t);
    end
  endtask

  initial begin
    reach_ticks = ReachableReset;
    retx_ticks = RetransmitReset;
    delay_ticks = ProbeDelayReset;
    for (int i = 0; i < Entries; i++) begin
      c_valid[i] = 1'b0; c_state[i] = StNone; c_hi[i] = '0; c_lo[i] = '0;
      c_mac[i] = '0; c_router[i] = 1'b0; c_probes[i] = '0; c_deadline[i] = '0;
    end
    for (int i = 0; i < 24; i++) begin
      pool_hi[i] = (i == 1) ? '1 : rand64();
      pool_lo[i] = (i == 1) ? '0 : rand64();
    end
    pool_hi[0] = '0;
    pool_lo[0] = '1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 23; recv_idle_pct = 49;
    test_directed();
    test_eviction();
    write_timer(RegReachable, 19'd1);
    write_timer(RegRetransmit, 19'h7FFFF);
    write_timer(RegProbeDelay, 19'd1);
    write_timer(2'd3, 19'd7);
    test_random(110);
    send_idle_pct = 49; recv_idle_pct = 23;
    write_timer(RegReachable, 19'h7FFFF);
    write_timer(RegRetransmit, 19'd1);
    write_timer(RegProbeDelay, 19'h7FFFF);
    test_random(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_timer(RegReachable, 19'd60);
    write_timer(RegRetransmit, 19'd20);
    write_timer(RegProbeDelay, 19'd30);
    test_random(110);
    drain_results();
    $display("%0d transactions sent, %0d results checked (%0d solicitations)",
             sent_count, result_count, solicit_count);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/nc_pkg.sv
sv/ipv6_neighbour_cache.sv
bench/tb_ipv6_neighbour_cache.sv
